[sv/two_button_menu_blink_code_controller_assert.svh]
// Assertion macros used by the menu controller checker.
`ifndef TWO_BUTTON_MENU_BLINK_CODE_CONTROLLER_ASSERT_SVH
`define TWO_BUTTON_MENU_BLINK_CODE_CONTROLLER_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define TBMBC_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tbmbc same-cycle check failed");

// Consequent holds in the cycle after the antecedent.
`define TBMBC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tbmbc next-cycle check failed");

`endif

[sv/tbmbc_pkg.sv]
// Types and constants for the two-button menu and blink code controller.
package tbmbc_pkg;

    localparam int NUM_SETTINGS = 3;
    localparam int CFG_ADDR_W   = 4;

    localparam logic [7:0] ENTRY_TICKS  = 8'd100;
    localparam logic [7:0] EXIT_TICKS   = 8'd200;
    localparam logic [7:0] MENU_REPEAT  = 8'd35;
    localparam logic [7:0] ERROR_REPEAT = 8'd30;
    localparam logic [3:0] EXIT_BLINKS  = 4'd6;
    localparam logic [3:0] ENTRY_BLINKS = 4'd3;
    localparam logic [2:0] DARK_MENU    = 3'd5;
    localparam logic [2:0] DARK_ERROR   = 3'd4;
    localparam logic [2:0] DARK_LEFT    = 3'd2;
    localparam logic [1:0] ON_TICKS     = 2'd2;
    localparam logic [2:0] CURSOR_NONE  = 3'd4;
    localparam logic [2:0] CURSOR_LAST  = 3'd2;
    localparam logic [1:0] SETTING_LAST = 2'd2;

    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    localparam logic [1:0] REG_SETTING_0 = 2'd0;
    localparam logic [1:0] REG_SETTING_1 = 2'd1;
    localparam logic [1:0] REG_SETTING_2 = 2'd2;

    typedef logic [NUM_SETTINGS-1:0][1:0] settings_t;

    typedef struct packed {
        logic       kind;
        logic [3:0] error_report;
        logic       sel_pressed;
        logic       enter_pressed;
    } item_t;

    typedef struct packed {
        logic [3:0] active_error;
        logic [1:0] setting_c;
        logic [1:0] setting_b;
        logic [1:0] setting_a;
        logic [2:0] cursor_index;
        logic       configuring;
        logic       led_on;
    } result_t;

    typedef struct packed {
        logic [3:0] blinks;
        logic [1:0] on_cnt;
        logic [2:0] off_cnt;
        logic       led;
    } blink_t;

endpackage

[sv/tbmbc_core.sv]
// Menu, error and blink state with its next-state logic for one transaction.
module tbmbc_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 item_accept,
    input  tbmbc_pkg::item_t     item,
    input  tbmbc_pkg::settings_t stored,
    output tbmbc_pkg::result_t   result
);

    logic                 in_menu_reg, in_menu_next;
    logic [7:0]           exit_reg, exit_next;
    logic [7:0]           entry_reg, entry_next;
    logic [2:0]           cursor_reg, cursor_next;
    tbmbc_pkg::settings_t ws_reg, ws_next;
    logic                 just_left_reg, just_left_next;
    logic [7:0]           repeat_reg, repeat_next;
    tbmbc_pkg::blink_t    blink_reg, blink_next;
    logic [3:0]           pend_reg, pend_next;
    logic                 enter_armed_reg, enter_armed_next;
    logic                 sel_armed_reg, sel_armed_next;
    logic                 enter_edge;
    logic                 sel_edge;
    logic [1:0]           new_value;

    function automatic tbmbc_pkg::blink_t start_blinks(tbmbc_pkg::blink_t b, logic [3:0] n);
        tbmbc_pkg::blink_t r;
        r        = b;
        r.blinks = n;
        r.on_cnt = tbmbc_pkg::ON_TICKS;
        r.led    = 1'b1;
        return r;
    endfunction

    function automatic tbmbc_pkg::blink_t blink_step(tbmbc_pkg::blink_t b, logic [2:0] dark);
        tbmbc_pkg::blink_t r;
        r = b;
        if (b.blinks != 4'd0) begin
            if (b.led) begin
                r.on_cnt = b.on_cnt - 2'd1;
                if (r.on_cnt == 2'd0) begin
                    r.off_cnt = dark;
                    r.led     = 1'b0;
                    r.blinks  = b.blinks - 4'd1;
                end
            end else begin
                r.off_cnt = b.off_cnt - 3'd1;
                if (r.off_cnt == 3'd0) begin
                    r.on_cnt = tbmbc_pkg::ON_TICKS;
                    r.led    = 1'b1;
                end
            end
        end
        return r;
    endfunction

    always_comb begin
        in_menu_next     = in_menu_reg;
        exit_next        = exit_reg;
        entry_next       = entry_reg;
        cursor_next      = cursor_reg;
        ws_next          = ws_reg;
        just_left_next   = just_left_reg;
        repeat_next      = repeat_reg;
        blink_next       = blink_reg;
        pend_next        = pend_reg;
        enter_armed_next = enter_armed_reg;
        sel_armed_next   = sel_armed_reg;
        enter_edge       = 1'b0;
        sel_edge         = 1'b0;
        new_value        = 2'd0;
        if (item_accept) begin
            if (item.kind == tbmbc_pkg::KIND_ERROR) begin
                if (item.error_report > pend_reg) begin
                    pend_next   = item.error_report;
                    repeat_next = tbmbc_pkg::ERROR_REPEAT;
                    blink_next  = start_blinks(blink_reg, item.error_report);
                end
            end else if (in_menu_reg) begin
                exit_next = exit_reg - 8'd1;
                if (exit_next == 8'd0) begin
                    in_menu_next   = 1'b0;
                    just_left_next = 1'b1;
                    repeat_next    = tbmbc_pkg::MENU_REPEAT;
                    blink_next     = start_blinks(blink_reg, tbmbc_pkg::EXIT_BLINKS);
                end else begin
                    enter_edge = item.enter_pressed && enter_armed_reg;
                    sel_edge   = !enter_edge && item.sel_pressed && sel_armed_reg;
                    if (enter_edge) begin
                        enter_armed_next = 1'b0;
                    end else begin
                        if (!item.enter_pressed) begin
                            enter_armed_next = 1'b1;
                        end
                        if (sel_edge) begin
                            sel_armed_next = 1'b0;
                        end else if (!item.sel_pressed) begin
                            sel_armed_next = 1'b1;
                        end
                    end
                    if (enter_edge) begin
                        exit_next   = tbmbc_pkg::EXIT_TICKS;
                        cursor_next = (cursor_reg >= tbmbc_pkg::CURSOR_LAST) ? 3'd0
                                                                              : cursor_reg + 3'd1;
                        repeat_next = tbmbc_pkg::MENU_REPEAT;
                        blink_next  = start_blinks(blink_reg, {1'b0, cursor_next} + 4'd1);
                    end else if (sel_edge && cursor_reg <= tbmbc_pkg::CURSOR_LAST) begin
                        new_value = (ws_reg[cursor_reg[1:0]] >= tbmbc_pkg::SETTING_LAST)
                                    ? 2'd0 : ws_reg[cursor_reg[1:0]] + 2'd1;
                        ws_next[cursor_reg[1:0]] = new_value;
                        exit_next   = tbmbc_pkg::EXIT_TICKS;
                        repeat_next = tbmbc_pkg::MENU_REPEAT;
                        blink_next  = start_blinks(blink_reg, {2'b00, new_value} + 4'd1);
                    end
                    blink_next = blink_step(blink_next, tbmbc_pkg::DARK_MENU);
                end
            end else begin
                if (just_left_reg) begin
                    if (blink_reg.blinks != 4'd0) begin
                        blink_next = blink_step(blink_reg, tbmbc_pkg::DARK_LEFT);
                    end else begin
                        just_left_next = 1'b0;
                    end
                end else if (pend_reg == 4'd0) begin
                    blink_next.led = 1'b0;
                end else begin
                    repeat_next = repeat_reg - 8'd1;
                    if (repeat_next == 8'd0) begin
                        repeat_next = tbmbc_pkg::ERROR_REPEAT;
                        blink_next  = start_blinks(blink_reg, pend_reg);
                    end
                    blink_next = blink_step(blink_next, tbmbc_pkg::DARK_ERROR);
                end
                if (item.enter_pressed && item.sel_pressed) begin
                    pend_next  = 4'd0;
                    entry_next = entry_reg - 8'd1;
                    if (entry_next == 8'd0) begin
                        in_menu_next = 1'b1;
                        exit_next    = tbmbc_pkg::EXIT_TICKS;
                        cursor_next  = tbmbc_pkg::CURSOR_NONE;
                        ws_next      = stored;
                        repeat_next  = tbmbc_pkg::MENU_REPEAT;
                        blink_next   = start_blinks(blink_next, tbmbc_pkg::ENTRY_BLINKS);
                    end
                end else begin
                    entry_next = tbmbc_pkg::ENTRY_TICKS;
                end
                if (item.sel_pressed) begin
                    pend_next = 4'd0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_menu_reg     <= 1'b0;
            exit_reg        <= 8'd0;
            entry_reg       <= tbmbc_pkg::ENTRY_TICKS;
            cursor_reg      <= tbmbc_pkg::CURSOR_NONE;
            ws_reg          <= '0;
            just_left_reg   <= 1'b0;
            repeat_reg      <= 8'd0;
            blink_reg       <= '0;
            pend_reg        <= 4'd0;
            enter_armed_reg <= 1'b0;
            sel_armed_reg   <= 1'b0;
        end else begin
            in_menu_reg     <= in_menu_next;
            exit_reg        <= exit_next;
            entry_reg       <= entry_next;
            cursor_reg      <= cursor_next;
            ws_reg          <= ws_next;
            just_left_reg   <= just_left_next;
            repeat_reg      <= repeat_next;
            blink_reg       <= blink_next;
            pend_reg        <= pend_next;
            enter_armed_reg <= enter_armed_next;
            sel_armed_reg   <= sel_armed_next;
        end
    end

    always_comb begin
        result.led_on       = blink_next.led;
        result.configuring  = in_menu_next;
        result.cursor_index = cursor_next;
        result.setting_a    = ws_next[0];
        result.setting_b    = ws_next[1];
        result.setting_c    = ws_next[2];
        result.active_error = pend_next;
    end

endmodule

[sv/two_button_menu_blink_code_controller.sv]
// A result appears on m_tdata in the cycle after its input transaction is accepted.
// Throughput: one transaction per cycle unless stalled; the state update is one pass of logic.
// The output register frees s_tready whenever it is empty or being drained.
// Reset (aresetn low, synchronous) clears the menu, blink and error state,
// the stored settings and the output valid; the entry counter loads its hold time.
module two_button_menu_blink_code_controller (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,  // enter_pressed, sel_pressed, error_report
    input  logic [0:0]                      s_tuser,  // kind
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // led_on, configuring, cursor_index, setting_a, setting_b, setting_c, active_error
    output logic [15:0]                     m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tbmbc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    tbmbc_pkg::settings_t stored_reg;
    tbmbc_pkg::item_t     item;
    tbmbc_pkg::result_t   result;
    logic                 accept;
    logic                 cfg_write;
    logic [1:0]           reg_index;
    logic                 m_tvalid_reg;
    logic [15:0]          m_tdata_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stored_reg <= '0;
        end else if (cfg_write) begin
            unique case (reg_index)
                tbmbc_pkg::REG_SETTING_0: stored_reg[0] <= pwdata[1:0];
                tbmbc_pkg::REG_SETTING_1: stored_reg[1] <= pwdata[1:0];
                tbmbc_pkg::REG_SETTING_2: stored_reg[2] <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_index)
            tbmbc_pkg::REG_SETTING_0: prdata = {30'd0, stored_reg[0]};
            tbmbc_pkg::REG_SETTING_1: prdata = {30'd0, stored_reg[1]};
            tbmbc_pkg::REG_SETTING_2: prdata = {30'd0, stored_reg[2]};
            default:                  prdata = 32'd0;
        endcase
    end

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        item.kind          = s_tuser[0];
        item.enter_pressed = s_tdata[0];
        item.sel_pressed   = s_tdata[1];
        item.error_report  = s_tdata[5:2];
    end

    tbmbc_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_accept (accept),
        .item        (item),
        .stored      (stored_reg),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= {1'b0, result};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[sv/tbmbc_checker.sv]
// Port-level checker for the menu controller, bound to the top level.
`include "two_button_menu_blink_code_controller_assert.svh"

module tbmbc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    logic out_stall;
    logic in_accept;
    logic cursor_ok;

    assign out_stall = m_tvalid && !m_tready;
    assign in_accept = s_tvalid && s_tready;
    assign cursor_ok = (m_tdata[4:2] <= 3'd2) || (m_tdata[4:2] == 3'd4);

    `TBMBC_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_stall, m_tvalid && $stable(m_tdata))
    `TBMBC_ASSERT_SAME(a_ready_when_empty, aclk, aresetn, !m_tvalid, s_tready)
    `TBMBC_ASSERT_NEXT(a_result_follows, aclk, aresetn, in_accept, m_tvalid)
    `TBMBC_ASSERT_SAME(a_cursor_legal, aclk, aresetn, m_tvalid, cursor_ok)

endmodule

bind two_button_menu_blink_code_controller tbmbc_checker u_tbmbc_checker (.*);
